@@ hw/rtl/ntj_pkg.sv @@
// ----------------------------------------------------------------------------
// ntj_pkg
// Shared types and codes for the gateway node table: operation and status
// codes, field widths and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package ntj_pkg;

   localparam int MODE_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int SLOT_W    = 4;
   localparam int TOTAL_W   = 5;
   localparam int TIME_W    = 32;
   localparam int ADDR_HI_W = 32;
   localparam int ADDR_LO_W = 64;
   localparam int ADDR_W    = ADDR_HI_W + ADDR_LO_W;
   localparam int TIMEOUT_W = 26;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30000);

   localparam logic [MODE_W-1:0] MODE_JOIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POLL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HEARD = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FIND  = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd3;

   typedef struct packed {
      logic accept;   // latch request, start the slot scan if needed
      logic finish;   // commit the operation and load the result register
   } ntj_cmd_type;

   typedef struct packed {
      logic need_scan;   // request on the port needs a pass over the slots
      logic scan_done;   // last slot is being compared this cycle
      logic out_free;    // result register can take a new result
   } ntj_stat_type;

endpackage

@@ hw/rtl/node_table_join_poll_expire_core.sv @@
// ----------------------------------------------------------------------------
// node_table_join_poll_expire_core
// Gateway node table with join, poll (with expiry), heard and find operations.
//
//   channel | ports  | direction | handshake
//   --------+--------+-----------+---------------------------------
//   request | req_*  | in        | req_valid / req_stall
//   result  | rsp_*  | out       | rsp_valid / rsp_stall
//   config  | csr_*  | in        | csr_valid / csr_ready (always 1)
//
// join, poll and find scan every slot in turn through the address/time memory
// read port and compare stage before they commit; heard and rejected or full
// joins go straight to commit.
// the next request is taken once the current one commits, even while the
// result register still waits on rsp_stall; commit waits for it to drain.
// synchronous reset clears all online flags, the count, the poll pointer and
// sets the timeout to 30000 ms; no clearing pass is needed.
// ----------------------------------------------------------------------------
module node_table_join_poll_expire_core #(
   parameter int NODES = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ntj_pkg::MODE_W-1:0]       req_mode,
   input  logic [ntj_pkg::TIME_W-1:0]       req_now,
   input  logic [ntj_pkg::ADDR_HI_W-1:0]    req_addr_high,
   input  logic [ntj_pkg::ADDR_LO_W-1:0]    req_addr_low,
   input  logic                             req_join_accepted,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ntj_pkg::STATUS_W-1:0]     rsp_status,
   output logic [ntj_pkg::SLOT_W-1:0]       rsp_slot,
   output logic [ntj_pkg::TOTAL_W-1:0]      rsp_online_total,
   output logic [ntj_pkg::TOTAL_W-1:0]      rsp_dropped_total,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ntj_pkg::TIMEOUT_W-1:0]    csr_online_timeout_ms
);

   ntj_pkg::ntj_cmd_type  cmd;
   ntj_pkg::ntj_stat_type stat;

   ntj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ntj_dp #(.NODES(NODES)) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_mode              (req_mode),
      .req_now               (req_now),
      .req_addr_high         (req_addr_high),
      .req_addr_low          (req_addr_low),
      .req_join_accepted     (req_join_accepted),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_online_total      (rsp_online_total),
      .rsp_dropped_total     (rsp_dropped_total),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_online_timeout_ms (csr_online_timeout_ms)
   );

   // commit only into a free result register
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid || !rsp_stall))
      else $error("commit while result register is occupied");

   // a committed operation shows up as a valid result
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("commit did not load a result");

   // after a transfer the block is busy until commit
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> req_stall)
      else $error("request taken while an operation is in flight");

   // accept and commit never coincide
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.finish))
      else $error("accept and commit in the same cycle");

endmodule

@@ hw/rtl/ntj_ram.sv @@
// ----------------------------------------------------------------------------
// ntj_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ntj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ntj_ctrl.sv @@
// ----------------------------------------------------------------------------
// ntj_ctrl
// Operation sequencer: takes a request, waits for the slot scan if it needs
// one, then commits once the result register is free.
// ----------------------------------------------------------------------------
module ntj_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ntj_pkg::ntj_stat_type stat,
   output ntj_pkg::ntj_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.need_scan ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hw/rtl/ntj_dp.sv @@
// ----------------------------------------------------------------------------
// ntj_dp
// Node table datapath: online flags, address and last-heard memories, scan
// pipeline with address compare and expiry check, and the result register.
// ----------------------------------------------------------------------------
module ntj_dp #(
   parameter int NODES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ntj_pkg::ntj_cmd_type                cmd,
   output ntj_pkg::ntj_stat_type               stat,
   input  logic [ntj_pkg::MODE_W-1:0]          req_mode,
   input  logic [ntj_pkg::TIME_W-1:0]          req_now,
   input  logic [ntj_pkg::ADDR_HI_W-1:0]       req_addr_high,
   input  logic [ntj_pkg::ADDR_LO_W-1:0]       req_addr_low,
   input  logic                                req_join_accepted,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ntj_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ntj_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [ntj_pkg::TOTAL_W-1:0]         rsp_online_total,
   output logic [ntj_pkg::TOTAL_W-1:0]         rsp_dropped_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ntj_pkg::TIMEOUT_W-1:0]       csr_online_timeout_ms
);

   localparam int IW      = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CW      = $clog2(NODES + 1);
   localparam int SLOT_W  = ntj_pkg::SLOT_W;
   localparam int TOTAL_W = ntj_pkg::TOTAL_W;
   localparam int TIME_W  = ntj_pkg::TIME_W;
   localparam int ADDR_W  = ntj_pkg::ADDR_W;
   localparam logic [IW-1:0] LAST_IDX  = IW'(NODES - 1);
   localparam logic [CW-1:0] NODES_CNT = CW'(NODES);

   // table state
   logic [NODES-1:0]              online_ff, online_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [IW-1:0]                 ptr_ff, ptr_in;
   logic [ntj_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;

   // latched request
   logic [ntj_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [TIME_W-1:0]          now_ff, now_in;
   logic [ADDR_W-1:0]          addr_ff, addr_in;
   logic                       acc_ff, acc_in;

   // scan pipeline
   logic          issue_on_ff, issue_on_in;
   logic [IW-1:0] issue_idx_ff, issue_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          found1_ff, found1_in;
   logic [IW-1:0] idx1_ff, idx1_in;
   logic          found2_ff, found2_in;
   logic [IW-1:0] idx2_ff, idx2_in;
   logic [CW-1:0] dropped_ff, dropped_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ntj_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]             rsp_slot_ff, rsp_slot_in;
   logic [TOTAL_W-1:0]            rsp_total_ff, rsp_total_in;
   logic [TOTAL_W-1:0]            rsp_drop_ff, rsp_drop_in;

   // memories
   logic              wr_addr_en, wr_time_en;
   logic [IW-1:0]     wr_idx;
   logic [ADDR_W-1:0] rd_addr_data;
   logic [TIME_W-1:0] rd_time_data;

   // scan decisions for the slot under compare
   logic              cur_on;
   logic              addr_match;
   logic              stale;
   logic [TIME_W-1:0] age;
   logic              scan_drop;
   logic              scan_hit1;
   logic              scan_hit2;

   ntj_ram #(.WIDTH(ADDR_W), .DEPTH(NODES)) u_addr_ram (
      .clock   (clock),
      .wr_en   (wr_addr_en),
      .wr_addr (wr_idx),
      .wr_data (addr_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_addr_data)
   );

   ntj_ram #(.WIDTH(TIME_W), .DEPTH(NODES)) u_time_ram (
      .clock   (clock),
      .wr_en   (wr_time_en),
      .wr_addr (wr_idx),
      .wr_data (now_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_time_data)
   );

   assign stat.need_scan = ((req_mode == ntj_pkg::MODE_JOIN) && req_join_accepted &&
                            (count_ff < NODES_CNT)) ||
                           (req_mode == ntj_pkg::MODE_POLL) ||
                           (req_mode == ntj_pkg::MODE_FIND);
   assign stat.scan_done = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   assign csr_ready = 1'b1;

   assign cur_on     = online_ff[cmp_idx_ff];
   assign addr_match = (rd_addr_data == addr_ff);
   assign age        = now_ff - rd_time_data;
   assign stale      = age > TIME_W'(timeout_ff);

   always_comb begin
      scan_drop = 1'b0;
      scan_hit1 = 1'b0;
      scan_hit2 = 1'b0;
      if (cmp_vld_ff) begin
         case (mode_ff)
            ntj_pkg::MODE_JOIN: begin
               // first free slot, judged before any duplicate is dropped
               scan_hit1 = !cur_on && !found1_ff;
               scan_drop = cur_on && addr_match;
            end
            ntj_pkg::MODE_POLL: begin
               // round robin: first survivor after the pointer, else first up to it
               scan_drop = cur_on && stale;
               scan_hit1 = cur_on && !stale && (cmp_idx_ff > ptr_ff) && !found1_ff;
               scan_hit2 = cur_on && !stale && (cmp_idx_ff <= ptr_ff) && !found2_ff;
            end
            ntj_pkg::MODE_FIND: begin
               scan_hit1 = cur_on && addr_match && !found1_ff;
            end
            default: begin
               scan_drop = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      online_in     = online_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      timeout_in    = timeout_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      addr_in       = addr_ff;
      acc_in        = acc_ff;
      issue_on_in   = issue_on_ff;
      issue_idx_in  = issue_idx_ff;
      cmp_vld_in    = issue_on_ff;
      cmp_idx_in    = issue_idx_ff;
      found1_in     = found1_ff;
      idx1_in       = idx1_ff;
      found2_in     = found2_ff;
      idx2_in       = idx2_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_drop_in   = rsp_drop_ff;
      wr_addr_en    = 1'b0;
      wr_time_en    = 1'b0;
      wr_idx        = ptr_ff;

      if (csr_valid) begin
         timeout_in = csr_online_timeout_ms;
      end

      if (cmd.accept) begin
         mode_in      = req_mode;
         now_in       = req_now;
         addr_in      = {req_addr_high, req_addr_low};
         acc_in       = req_join_accepted;
         issue_on_in  = stat.need_scan;
         issue_idx_in = '0;
         found1_in    = 1'b0;
         found2_in    = 1'b0;
         dropped_in   = '0;
      end

      if (issue_on_ff) begin
         if (issue_idx_ff == LAST_IDX) begin
            issue_on_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + IW'(1);
         end
      end

      if (scan_hit1) begin
         found1_in = 1'b1;
         idx1_in   = cmp_idx_ff;
      end
      if (scan_hit2) begin
         found2_in = 1'b1;
         idx2_in   = cmp_idx_ff;
      end
      if (scan_drop) begin
         online_in[cmp_idx_ff] = 1'b0;
         count_in              = count_ff - CW'(1);
         dropped_in            = dropped_ff + CW'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_drop_in   = TOTAL_W'(dropped_ff);
         rsp_status_in = ntj_pkg::STAT_NONE;
         rsp_slot_in   = '0;
         case (mode_ff)
            ntj_pkg::MODE_JOIN: begin
               if (count_ff >= NODES_CNT) begin
                  rsp_status_in = ntj_pkg::STAT_FULL;
               end else if (!acc_ff) begin
                  rsp_status_in = ntj_pkg::STAT_REJECT;
               end else if (found1_ff) begin
                  rsp_status_in      = ntj_pkg::STAT_OK;
                  rsp_slot_in        = SLOT_W'(idx1_ff);
                  online_in[idx1_ff] = 1'b1;
                  count_in           = count_ff + CW'(1);
                  wr_addr_en         = 1'b1;
                  wr_time_en         = 1'b1;
                  wr_idx             = idx1_ff;
               end else begin
                  rsp_status_in = ntj_pkg::STAT_FULL;
               end
            end
            ntj_pkg::MODE_POLL: begin
               rsp_slot_in = SLOT_W'(ptr_ff);
               if (count_ff != '0) begin
                  if (found1_ff) begin
                     rsp_status_in = ntj_pkg::STAT_OK;
                     ptr_in        = idx1_ff;
                     rsp_slot_in   = SLOT_W'(idx1_ff);
                  end else if (found2_ff) begin
                     rsp_status_in = ntj_pkg::STAT_OK;
                     ptr_in        = idx2_ff;
                     rsp_slot_in   = SLOT_W'(idx2_ff);
                  end
               end
            end
            ntj_pkg::MODE_HEARD: begin
               wr_time_en    = 1'b1;
               wr_idx        = ptr_ff;
               rsp_slot_in   = SLOT_W'(ptr_ff);
               rsp_status_in = online_ff[ptr_ff] ? ntj_pkg::STAT_OK : ntj_pkg::STAT_NONE;
            end
            default: begin
               if (found1_ff) begin
                  rsp_status_in = ntj_pkg::STAT_OK;
                  rsp_slot_in   = SLOT_W'(idx1_ff);
               end
            end
         endcase
         rsp_total_in = TOTAL_W'(count_in);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         online_ff    <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         timeout_ff   <= ntj_pkg::TIMEOUT_RESET;
         issue_on_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         online_ff    <= online_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         timeout_ff   <= timeout_in;
         issue_on_ff  <= issue_on_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      now_ff        <= now_in;
      addr_ff       <= addr_in;
      acc_ff        <= acc_in;
      issue_idx_ff  <= issue_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found1_ff     <= found1_in;
      idx1_ff       <= idx1_in;
      found2_ff     <= found2_in;
      idx2_ff       <= idx2_in;
      dropped_ff    <= dropped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_online_total  = rsp_total_ff;
   assign rsp_dropped_total = rsp_drop_ff;

endmodule

@@ sim/node_table_check_pkg.sv @@
// ----------------------------------------------------------------------------
// node_table_check_pkg
// Request and reply records for the node table bench, plus a tracker class
// that mirrors the slot table, predicts each reply and checks the replies
// that come back from the block.
// ----------------------------------------------------------------------------
package node_table_check_pkg;

   import ntj_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS = 16;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [TIME_W-1:0]    now;
      logic [ADDR_HI_W-1:0] addr_high;
      logic [ADDR_LO_W-1:0] addr_low;
      logic                 join_accepted;
   } table_request_t;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [TOTAL_W-1:0]  online_total;
      logic [TOTAL_W-1:0]  dropped_total;
   } table_reply_t;

   class node_table_tracker;
      logic [TIMEOUT_W-1:0] timeout_ms;
      bit                   online [TABLE_SLOTS];
      logic [ADDR_W-1:0]    address [TABLE_SLOTS];
      logic [TIME_W-1:0]    heard_at [TABLE_SLOTS];
      int                   poll_ptr;
      int                   online_count;
      table_reply_t         expected_replies [$];
      int                   failures;
      int                   checked;
      int                   full_seen;
      int                   drops_seen;

      function new();
         timeout_ms   = TIMEOUT_RESET;
         poll_ptr     = 0;
         online_count = 0;
         failures     = 0;
         checked      = 0;
         full_seen    = 0;
         drops_seen   = 0;
         for (int k = 0; k < TABLE_SLOTS; k++) begin
            online[k]   = 1'b0;
            address[k]  = '0;
            heard_at[k] = '0;
         end
      endfunction

      function void set_timeout(logic [TIMEOUT_W-1:0] value);
         timeout_ms = value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void drop_slot(int k);
         online[k]  = 1'b0;
         address[k] = '0;
         if (online_count > 0) online_count--;
      endfunction

      // predict the reply to one accepted request and update the table copy
      function void note_request(table_request_t r);
         table_reply_t      e;
         int                free_slot;
         int                p;
         int                dropped;
         logic [ADDR_W-1:0] a;
         logic [TIME_W-1:0] age;
         e.status = STAT_OK;
         e.slot   = '0;
         dropped  = 0;
         a        = {r.addr_high, r.addr_low};
         case (r.mode)
            MODE_JOIN: begin
               // fullness is tested ahead of acceptance
               if (online_count >= TABLE_SLOTS) begin
                  e.status = STAT_FULL;
               end else if (!r.join_accepted) begin
                  e.status = STAT_REJECT;
               end else begin
                  free_slot = -1;
                  for (int k = 0; k < TABLE_SLOTS; k++)
                     if (!online[k] && free_slot < 0) free_slot = k;
                  if (free_slot < 0) begin
                     e.status = STAT_FULL;
                  end else begin
                     online[free_slot]   = 1'b1;
                     address[free_slot]  = a;
                     heard_at[free_slot] = r.now;
                     online_count++;
                     for (int k = 0; k < TABLE_SLOTS; k++) begin
                        if (k != free_slot && online[k] && address[k] == a) begin
                           drop_slot(k);
                           dropped++;
                        end
                     end
                     e.slot = SLOT_W'(free_slot);
                  end
               end
               if (e.status == STAT_FULL) full_seen++;
            end
            MODE_POLL: begin
               for (int k = 0; k < TABLE_SLOTS; k++) begin
                  age = r.now - heard_at[k];
                  if (online[k] && age > TIME_W'(timeout_ms)) begin
                     drop_slot(k);
                     dropped++;
                  end
               end
               e.status = STAT_NONE;
               if (online_count != 0) begin
                  p = poll_ptr;
                  for (int k = 0; k < TABLE_SLOTS; k++) begin
                     p = (p + 1) % TABLE_SLOTS;
                     if (online[p]) begin
                        poll_ptr = p;
                        e.status = STAT_OK;
                        break;
                     end
                  end
               end
               e.slot = SLOT_W'(poll_ptr);
            end
            MODE_HEARD: begin
               // time is written even when the polled slot is offline
               heard_at[poll_ptr] = r.now;
               e.status = online[poll_ptr] ? STAT_OK : STAT_NONE;
               e.slot   = SLOT_W'(poll_ptr);
            end
            MODE_FIND: begin
               e.status = STAT_NONE;
               for (int k = 0; k < TABLE_SLOTS; k++) begin
                  if (online[k] && address[k] == a) begin
                     e.status = STAT_OK;
                     e.slot   = SLOT_W'(k);
                     break;
                  end
               end
            end
            default: ;
         endcase
         e.online_total  = TOTAL_W'(online_count);
         e.dropped_total = TOTAL_W'(dropped);
         drops_seen += dropped;
         expected_replies.push_back(e);
      endfunction

      function void check_result(table_reply_t got);
         table_reply_t want;
         checked++;
         if (expected_replies.size() == 0) begin
            $error("reply with nothing outstanding: status %0d slot %0d",
                   got.status, got.slot);
            failures++;
            return;
         end
         want = expected_replies.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            failures++;
         end
         if (got.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            failures++;
         end
         if (got.online_total !== want.online_total) begin
            $error("online_total: expected %0d, actual %0d",
                   want.online_total, got.online_total);
            failures++;
         end
         if (got.dropped_total !== want.dropped_total) begin
            $error("dropped_total: expected %0d, actual %0d",
                   want.dropped_total, got.dropped_total);
            failures++;
         end
      endfunction
   endclass

endpackage

@@ sim/tb_node_table_join_poll_expire_core.sv @@
// ----------------------------------------------------------------------------
// tb_node_table_join_poll_expire_core
// Drives join, poll, heard and find requests into the node table core under
// several timeout settings and idle patterns, and checks every reply against
// a tracked copy of the slot table.
// ----------------------------------------------------------------------------
module tb_node_table_join_poll_expire_core;

   import ntj_pkg::*;
   import node_table_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int ADDR_POOL    = 24;
   localparam int DRAIN_CYCLES = TABLE_SLOTS + 6;

   logic                  clock                 = 1'b0;
   logic                  reset                 = 1'b1;
   logic                  req_valid             = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode              = MODE_JOIN;
   logic [TIME_W-1:0]     req_now               = '0;
   logic [ADDR_HI_W-1:0]  req_addr_high         = '0;
   logic [ADDR_LO_W-1:0]  req_addr_low          = '0;
   logic                  req_join_accepted     = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall             = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]     rsp_slot;
   logic [TOTAL_W-1:0]    rsp_online_total;
   logic [TOTAL_W-1:0]    rsp_dropped_total;
   logic                  csr_valid             = 1'b0;
   logic                  csr_ready;
   logic [TIMEOUT_W-1:0]  csr_online_timeout_ms = '0;

   int                    send_idle_pct = 0;
   int                    stall_pct     = 0;
   int                    cycle_count   = 0;
   logic [TIME_W-1:0]     now_ms        = '0;
   logic [TIMEOUT_W-1:0]  timeout_now   = TIMEOUT_RESET;
   logic [ADDR_W-1:0]     addr_pool [ADDR_POOL];
   node_table_tracker     tracker;

   node_table_join_poll_expire_core #(
      .NODES(TABLE_SLOTS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_now               (req_now),
      .req_addr_high         (req_addr_high),
      .req_addr_low          (req_addr_low),
      .req_join_accepted     (req_join_accepted),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_slot              (rsp_slot),
      .rsp_online_total      (rsp_online_total),
      .rsp_dropped_total     (rsp_dropped_total),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_online_timeout_ms (csr_online_timeout_ms)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // both sides sampled at the edge, request side first
   always @(posedge clock) begin : monitor
      table_request_t seen_req;
      table_reply_t   seen_rsp;
      if (!reset && tracker != null) begin
         if (req_valid && !req_stall) begin
            seen_req.mode          = req_mode;
            seen_req.now           = req_now;
            seen_req.addr_high     = req_addr_high;
            seen_req.addr_low      = req_addr_low;
            seen_req.join_accepted = req_join_accepted;
            tracker.note_request(seen_req);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_rsp.status        = rsp_status;
            seen_rsp.slot          = rsp_slot;
            seen_rsp.online_total  = rsp_online_total;
            seen_rsp.dropped_total = rsp_dropped_total;
            tracker.check_result(seen_rsp);
         end
      end
   end

   function automatic table_request_t make_request(logic [MODE_W-1:0] mode,
                                                   logic [TIME_W-1:0] now,
                                                   logic [ADDR_W-1:0] addr,
                                                   logic accepted);
      table_request_t r;
      r.mode          = mode;
      r.now           = now;
      r.addr_high     = addr[ADDR_W-1:ADDR_LO_W];
      r.addr_low      = addr[ADDR_LO_W-1:0];
      r.join_accepted = accepted;
      return r;
   endfunction

   // mostly small steps, now and then a jump past the timeout or anywhere
   function automatic logic [TIME_W-1:0] advance_clock_ms();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)
         now_ms = $urandom;
      else if (r < 8)
         now_ms = now_ms + timeout_now + $urandom_range(1, 2000);
      else
         now_ms = now_ms + $urandom_range(0, timeout_now / 6 + 3);
      return now_ms;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      if ($urandom_range(0, 99) < 88)
         return addr_pool[$urandom_range(0, ADDR_POOL - 1)];
      return {$urandom, $urandom, $urandom};
   endfunction

   task automatic drive_request(input table_request_t r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= r.mode;
      req_now           <= r.now;
      req_addr_high     <= r.addr_high;
      req_addr_low      <= r.addr_low;
      req_join_accepted <= r.join_accepted;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_valid             <= 1'b1;
      csr_online_timeout_ms <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_timeout(value);
      timeout_now = value;
   endtask

   task automatic run_directed();
      drive_request(make_request(MODE_POLL, 32'd0, addr_pool[0], 1'b1));
      drive_request(make_request(MODE_FIND, 32'd1, addr_pool[1], 1'b0));
      drive_request(make_request(MODE_JOIN, 32'd2, addr_pool[1], 1'b0));
      // fill every slot, the first with an all-zero and the second with an
      // all-ones address
      for (int i = 0; i < TABLE_SLOTS; i++)
         drive_request(make_request(MODE_JOIN, 32'(10 + i), addr_pool[i], 1'b1));
      drive_request(make_request(MODE_JOIN, 32'd26, addr_pool[16], 1'b1));
      drive_request(make_request(MODE_JOIN, 32'd27, addr_pool[17], 1'b0));
      drive_request(make_request(MODE_FIND, 32'd28, addr_pool[1], 1'b0));
      // all but the newest slot are just past the timeout
      drive_request(make_request(MODE_POLL, 32'd30025, addr_pool[0], 1'b0));
      drive_request(make_request(MODE_HEARD, 32'd30030, addr_pool[0], 1'b0));
      // same address again: lands in slot 0 and evicts the old copy
      drive_request(make_request(MODE_JOIN, 32'd30031, addr_pool[15], 1'b1));
      drive_request(make_request(MODE_FIND, 32'd30032, addr_pool[15], 1'b1));
      drive_request(make_request(MODE_POLL, 32'hFFFF_FFFF, addr_pool[1], 1'b1));
      now_ms = 32'hFFFF_FFFF;
   endtask

   task automatic run_random(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            drive_request(make_request(MODE_JOIN, advance_clock_ms(), pick_address(),
                                       $urandom_range(0, 9) != 0));
            sent++;
         end else if (pick < 65) begin
            // poll followed closely by the node answering
            drive_request(make_request(MODE_POLL, advance_clock_ms(), pick_address(),
                                       1'($urandom)));
            now_ms = now_ms + $urandom_range(0, 20);
            drive_request(make_request(MODE_HEARD, now_ms, pick_address(),
                                       1'($urandom)));
            sent += 2;
         end else if (pick < 72) begin
            drive_request(make_request(MODE_POLL, advance_clock_ms(), pick_address(),
                                       1'($urandom)));
            sent++;
         end else if (pick < 80) begin
            drive_request(make_request(MODE_HEARD, advance_clock_ms(), pick_address(),
                                       1'($urandom)));
            sent++;
         end else if (pick < 95) begin
            drive_request(make_request(MODE_FIND, advance_clock_ms(), pick_address(),
                                       1'($urandom)));
            sent++;
         end else begin
            drive_request(make_request(MODE_W'($urandom_range(0, 3)), $urandom,
                                       {$urandom, $urandom, $urandom}, 1'($urandom)));
            sent++;
         end
      end
   endtask

   task automatic run_phase(input logic [TIMEOUT_W-1:0] timeout, input int idle_pct,
                            input int hold_pct, input int count);
      settle();
      write_timeout(timeout);
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      run_random(count);
   endtask

   initial begin
      tracker = new();
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < ADDR_POOL; i++)
         addr_pool[i] = {$urandom, $urandom, $urandom};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_phase(TIMEOUT_W'(0), 0, 0, 60);
      run_phase(TIMEOUT_W'(65535000), 69, 0, 90);
      run_phase(TIMEOUT_W'(999), 0, 69, 90);
      run_phase(TIMEOUT_W'($urandom_range(0, 65535000)), 16, 16, 90);
      run_phase(TIMEOUT_RESET, 0, 0, 60);
      settle();

      $display("checked %0d replies across five timeout settings and four idle patterns",
               tracker.checked);
      $display("table-full joins seen: %0d, slots dropped by expiry or duplicates: %0d",
               tracker.full_seen, tracker.drops_seen);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/ntj_pkg.sv
hw/rtl/ntj_ram.sv
hw/rtl/ntj_ctrl.sv
hw/rtl/ntj_dp.sv
hw/rtl/node_table_join_poll_expire_core.sv
sim/node_table_check_pkg.sv
sim/tb_node_table_join_poll_expire_core.sv
